// ===== hw/rtl/tcw_pkg.sv =====
// ============================================================================
// tcw_pkg - shared types and constants for the text console writer
// Request codes, word layouts, sequencer states and the screen memory port.
// ============================================================================
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Widest screen store: 16384 cells.
    localparam int MEM_AW_MAX  = 14;

    localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
    localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

    typedef logic [15:0]           t_cell;
    typedef logic [MEM_AW_MAX-1:0] t_mem_addr;
    typedef logic [4:0]            t_row_field;
    typedef logic [6:0]            t_col_field;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_SCROLL_END
    } t_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_word;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_out_word;

    typedef struct packed {
        logic      we;
        t_mem_addr waddr;
        t_cell     wdata;
        logic      re;
        t_mem_addr raddr;
    } t_mem_req;

endpackage

// ===== hw/rtl/tcw_screen_mem.sv =====
// ============================================================================
// tcw_screen_mem - screen cell store
// One write port and one read port, read data registered.
// ============================================================================
module tcw_screen_mem #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic              i_clk,
    input  tcw_pkg::t_mem_req i_req,
    output tcw_pkg::t_cell    o_rdata
);

    localparam int AW = $clog2(DEPTH);

    tcw_pkg::t_cell mem [DEPTH];
    tcw_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// ============================================================================
// tcw_ctrl - request sequencer and cursor for the text console writer
// Runs put, read, clear and scroll against the screen memory.
// ============================================================================
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  tcw_pkg::t_in_word  i_word,
    output logic               o_strobe,
    output tcw_pkg::t_out_word o_word,
    output tcw_pkg::t_mem_req  o_mem_req,
    input  tcw_pkg::t_cell     i_mem_rdata
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int COPY_LAST = CELLS - COLUMNS;
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int AW        = $clog2(CELLS);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    tcw_pkg::t_state    r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_wb_vld, n_wb_vld;
    logic               r_wb_copy, n_wb_copy;
    logic [AW-1:0]      r_wb_addr, n_wb_addr;
    logic               r_rd_ok, n_rd_ok;
    logic               r_strobe, n_strobe;
    tcw_pkg::t_out_word r_out, n_out;

    logic          row_last, col_last, is_nl, row_adv, put_scroll, rd_ok, idx_last, copy_ok;
    logic [RW-1:0] put_row;
    logic [CW-1:0] put_col;
    logic [AW-1:0] cur_addr, rd_addr;

    // Cursor arithmetic for a put, read address checks and sweep bounds.
    always_comb begin
        row_last   = (32'(r_row) == ROWS - 1);
        col_last   = (32'(r_col) == COLUMNS - 1);
        is_nl      = (i_word.char_code == tcw_pkg::NEWLINE_CHAR);
        row_adv    = is_nl || col_last;
        put_scroll = row_adv && row_last;
        put_col    = row_adv ? '0 : r_col + CW'(1);
        put_row    = (row_adv && !row_last) ? r_row + RW'(1) : r_row;
        cur_addr   = AW'(32'(r_row) * COLUMNS + 32'(r_col));
        rd_ok      = (32'(i_word.read_row) < ROWS) && (32'(i_word.read_col) < COLUMNS);
        rd_addr    = AW'(32'(i_word.read_row) * COLUMNS + 32'(i_word.read_col));
        idx_last   = (32'(r_idx) == CELLS - 1);
        copy_ok    = (32'(r_idx) < COPY_LAST);
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_idx     = r_idx;
        n_wb_vld  = 1'b0;
        n_wb_copy = r_wb_copy;
        n_wb_addr = r_wb_addr;
        n_rd_ok   = r_rd_ok;
        n_strobe  = 1'b0;
        n_out     = r_out;
        o_mem_req = '0;

        case (r_state)
            tcw_pkg::ST_INIT: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = tcw_pkg::t_mem_addr'(r_idx);
                o_mem_req.wdata = tcw_pkg::BLANK_CELL;
                n_idx           = idx_last ? '0 : r_idx + AW'(1);
                if (idx_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (tcw_pkg::t_req'(i_word.req_type))
                        tcw_pkg::REQ_PUT: begin
                            o_mem_req.we    = !is_nl;
                            o_mem_req.waddr = tcw_pkg::t_mem_addr'(cur_addr);
                            o_mem_req.wdata = {i_word.attribute, i_word.char_code};
                            n_row           = put_row;
                            n_col           = put_col;
                            if (put_scroll) begin
                                n_idx   = '0;
                                n_state = tcw_pkg::ST_SCROLL;
                            end else begin
                                n_strobe         = 1'b1;
                                n_out.cursor_row = tcw_pkg::t_row_field'(put_row);
                                n_out.cursor_col = tcw_pkg::t_col_field'(put_col);
                                n_out.cell_char  = '0;
                                n_out.cell_attr  = '0;
                                n_out.scrolled   = 1'b0;
                            end
                        end
                        tcw_pkg::REQ_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_idx   = '0;
                            n_state = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::REQ_READ: begin
                            o_mem_req.re    = rd_ok;
                            o_mem_req.raddr = tcw_pkg::t_mem_addr'(rd_addr);
                            n_rd_ok         = rd_ok;
                            n_state         = tcw_pkg::ST_READ;
                        end
                        default: begin
                            n_strobe         = 1'b1;
                            n_out.cursor_row = tcw_pkg::t_row_field'(r_row);
                            n_out.cursor_col = tcw_pkg::t_col_field'(r_col);
                            n_out.cell_char  = '0;
                            n_out.cell_attr  = '0;
                            n_out.scrolled   = 1'b0;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                n_strobe         = 1'b1;
                n_out.cursor_row = tcw_pkg::t_row_field'(r_row);
                n_out.cursor_col = tcw_pkg::t_col_field'(r_col);
                n_out.cell_char  = r_rd_ok ? i_mem_rdata[7:0] : 8'd0;
                n_out.cell_attr  = r_rd_ok ? i_mem_rdata[15:8] : 8'd0;
                n_out.scrolled   = 1'b0;
                n_state          = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = tcw_pkg::t_mem_addr'(r_idx);
                o_mem_req.wdata = tcw_pkg::BLANK_CELL;
                n_idx           = idx_last ? '0 : r_idx + AW'(1);
                if (idx_last) begin
                    n_strobe         = 1'b1;
                    n_out.cursor_row = '0;
                    n_out.cursor_col = '0;
                    n_out.cell_char  = '0;
                    n_out.cell_attr  = '0;
                    n_out.scrolled   = 1'b0;
                    n_state          = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                // Write back the cell read last cycle (a blank for the last row), read one row ahead.
                o_mem_req.we    = r_wb_vld;
                o_mem_req.waddr = tcw_pkg::t_mem_addr'(r_wb_addr);
                o_mem_req.wdata = r_wb_copy ? i_mem_rdata : tcw_pkg::BLANK_CELL;
                o_mem_req.re    = copy_ok;
                o_mem_req.raddr = tcw_pkg::t_mem_addr'(AW'(32'(r_idx) + COLUMNS));
                n_wb_vld        = 1'b1;
                n_wb_addr       = r_idx;
                n_wb_copy       = copy_ok;
                n_idx           = idx_last ? '0 : r_idx + AW'(1);
                if (idx_last) begin
                    n_state = tcw_pkg::ST_SCROLL_END;
                end
            end
            tcw_pkg::ST_SCROLL_END: begin
                o_mem_req.we     = r_wb_vld;
                o_mem_req.waddr  = tcw_pkg::t_mem_addr'(r_wb_addr);
                o_mem_req.wdata  = r_wb_copy ? i_mem_rdata : tcw_pkg::BLANK_CELL;
                n_strobe         = 1'b1;
                n_out.cursor_row = tcw_pkg::t_row_field'(r_row);
                n_out.cursor_col = tcw_pkg::t_col_field'(r_col);
                n_out.cell_char  = '0;
                n_out.cell_attr  = '0;
                n_out.scrolled   = 1'b1;
                n_state          = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::ST_INIT;
            r_row    <= '0;
            r_col    <= '0;
            r_idx    <= '0;
            r_wb_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_idx    <= n_idx;
            r_wb_vld <= n_wb_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_copy <= n_wb_copy;
        r_wb_addr <= n_wb_addr;
        r_rd_ok   <= n_rd_ok;
        r_out     <= n_out;
    end

    assign o_busy   = (r_state != tcw_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_word   = r_out;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor left the screen");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.scrolled) |-> (r_row == ROW_LAST))
        else $error("scroll did not leave cursor on last row");

    a_wb_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> (r_state == tcw_pkg::ST_SCROLL || r_state == tcw_pkg::ST_SCROLL_END))
        else $error("scroll write-back outside scroll");

    a_no_strobe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_SCROLL || r_state == tcw_pkg::ST_CLEAR
         || r_state == tcw_pkg::ST_INIT) |-> !r_strobe)
        else $error("result strobe during a sweep");

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// ============================================================================
// text_console_writer_unit - character-cell text console, top level
// A put or an unused code gives its result in the cycle after acceptance;
// a read goes through one memory read and the read state. Clear and a put
// that scrolls are set by the sweep over the single memory port pair (one
// cell per cycle). After reset busy stays high while the screen store is
// blanked. Results are never stalled: o_strobe marks each one for exactly
// one cycle.
// ============================================================================
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request side: a word is taken when start is high and busy is low.
    input  logic               start,
    output logic               busy,
    input  tcw_pkg::t_in_word  i_word,
    // Result side: one word per request, valid while o_strobe is high.
    output logic               o_strobe,
    output tcw_pkg::t_out_word o_word
);

    // Memory request and read data between the sequencer and the store.
    tcw_pkg::t_mem_req mem_req;
    tcw_pkg::t_cell    mem_rdata;

    // Sequencer: holds the cursor, decodes requests and walks the store
    // for clear and scroll; owns the result register.
    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_word      (i_word),
        .o_strobe    (o_strobe),
        .o_word      (o_word),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // Screen store: ROWS x COLUMNS cells, attribute high byte, char low byte.
    tcw_screen_mem #(
        .DEPTH (ROWS * COLUMNS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== test/text_console_writer_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// text_console_writer_unit_tb - self-checking bench for the text console
// Drives put, clear, read and unused requests through the start/busy
// handshake, tracks screen contents and cursor in a local copy, and checks
// every result word field by field against the oldest predicted word.
// ============================================================================
module text_console_writer_unit_tb;

    localparam int SCREEN_COLS  = tcw_pkg::COLUMNS_DEF;
    localparam int SCREEN_ROWS  = tcw_pkg::ROWS_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int RANDOM_ITEMS = 540;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    tcw_pkg::t_in_word  i_word;
    logic               o_strobe;
    tcw_pkg::t_out_word o_word;

    // Local copy of the console: screen cells and cursor.
    tcw_pkg::t_cell     shadow_cells [SCREEN_CELLS];
    int                 cursor_row_now;
    int                 cursor_col_now;

    // Predicted result words, oldest first.
    tcw_pkg::t_out_word pending_console_words [$];

    int                 sent_count;
    int                 checked_count;
    int                 mismatch_count;
    bit                 idle_on;

    text_console_writer_unit #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Console predictor
    // ------------------------------------------------------------------------

    // Fill every cell with a space on white-on-black and home the cursor.
    function automatic void blank_console();
        for (int i = 0; i < SCREEN_CELLS; i++) begin
            shadow_cells[i] = tcw_pkg::BLANK_CELL;
        end
        cursor_row_now = 0;
        cursor_col_now = 0;
    endfunction

    // Apply one request word to the local console and return its result word.
    function automatic tcw_pkg::t_out_word console_step(tcw_pkg::t_in_word w);
        tcw_pkg::t_out_word r;
        tcw_pkg::t_cell     read_cell;
        r = '0;
        case (tcw_pkg::t_req'(w.req_type))
            tcw_pkg::REQ_PUT: begin
                if (w.char_code == tcw_pkg::NEWLINE_CHAR) begin
                    // Newline writes nothing, just moves to the next row.
                    cursor_row_now++;
                    cursor_col_now = 0;
                end else begin
                    shadow_cells[cursor_row_now * SCREEN_COLS + cursor_col_now] =
                        {w.attribute, w.char_code};
                    cursor_col_now++;
                    if (cursor_col_now >= SCREEN_COLS) begin
                        cursor_col_now = 0;
                        cursor_row_now++;
                    end
                end
                // Past the bottom: shift every row up, blank the last one.
                if (cursor_row_now >= SCREEN_ROWS) begin
                    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                        shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
                    end
                    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
                        shadow_cells[i] = tcw_pkg::BLANK_CELL;
                    end
                    cursor_row_now = SCREEN_ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            tcw_pkg::REQ_CLEAR: begin
                blank_console();
            end
            tcw_pkg::REQ_READ: begin
                // Out-of-range reads return an all-zero cell.
                if (w.read_row < SCREEN_ROWS && w.read_col < SCREEN_COLS) begin
                    read_cell   = shadow_cells[w.read_row * SCREEN_COLS + w.read_col];
                    r.cell_char = read_cell[7:0];
                    r.cell_attr = read_cell[15:8];
                end
            end
            default: begin
                // Unused code: nothing changes.
            end
        endcase
        r.cursor_row = tcw_pkg::t_row_field'(cursor_row_now);
        r.cursor_col = tcw_pkg::t_col_field'(cursor_col_now);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------

    function automatic tcw_pkg::t_in_word make_word(tcw_pkg::t_req req, int ch, int attr,
                                                    int row, int col);
        tcw_pkg::t_in_word w;
        w.req_type  = req;
        w.char_code = 8'(ch);
        w.attribute = 8'(attr);
        w.read_row  = 5'(row);
        w.read_col  = 7'(col);
        return w;
    endfunction

    // Random content in every field but the request code, full field width.
    function automatic tcw_pkg::t_in_word random_word(tcw_pkg::t_req req);
        return make_word(req, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 31), $urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Send one word: optionally hold start low for a short burst, then raise
    // start and wait for the edge that takes the word.
    task automatic send_word(input tcw_pkg::t_in_word w);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_console_words.push_back(console_step(w));
        sent_count++;
    endtask

    task automatic send_put(input int ch, input int attr);
        tcw_pkg::t_in_word w;
        w           = random_word(tcw_pkg::REQ_PUT);
        w.char_code = 8'(ch);
        w.attribute = 8'(attr);
        send_word(w);
    endtask

    task automatic send_read(input int row, input int col);
        tcw_pkg::t_in_word w;
        w          = random_word(tcw_pkg::REQ_READ);
        w.read_row = 5'(row);
        w.read_col = 7'(col);
        send_word(w);
    endtask

    // Printable-ish random character that is never a newline.
    function automatic int text_char();
        int ch;
        ch = $urandom_range(0, 255);
        return (ch == tcw_pkg::NEWLINE_CHAR) ? tcw_pkg::BLANK_CHAR : ch;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                      checked_count, name, got, want));
        end
    endtask

    // Results cannot be held off: take each strobed word at the edge.
    always @(posedge i_clk) begin : check_results
        tcw_pkg::t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (pending_console_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", o_word));
            end else begin
                want = pending_console_words.pop_front();
                check_field("cursor_row", o_word.cursor_row, want.cursor_row);
                check_field("cursor_col", o_word.cursor_col, want.cursor_col);
                check_field("cell_char",  o_word.cell_char,  want.cell_char);
                check_field("cell_attr",  o_word.cell_attr,  want.cell_attr);
                check_field("scrolled",   o_word.scrolled,   want.scrolled);
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every request code, out-of-range reads.
    task automatic test_basic_requests();
        send_read(0, 0);                                  // blank after reset
        send_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        send_put(0, 0);
        send_put(255, 255);
        send_put(tcw_pkg::BLANK_CHAR, tcw_pkg::BLANK_ATTR);
        send_read(0, 0);
        send_read(0, 1);
        send_read(SCREEN_ROWS, 0);                        // row past bottom
        send_read(0, SCREEN_COLS);                        // column past right edge
        send_read(31, 127);                               // both fields at max
        send_word(make_word(tcw_pkg::REQ_NONE, 255, 255, 31, 127));
        send_word(make_word(tcw_pkg::REQ_NONE, 0, 0, 0, 0));
        send_put(tcw_pkg::NEWLINE_CHAR, 255);
        send_put(8'h41, 8'h1E);
        send_read(1, 0);
        send_word(make_word(tcw_pkg::REQ_CLEAR, 255, 255, 31, 127));
        send_read(0, 1);
        send_read(1, 0);
    endtask

    // Fill one row; the last column wraps the cursor to the next row.
    task automatic test_line_wrap();
        send_word(random_word(tcw_pkg::REQ_CLEAR));
        for (int c = 0; c < SCREEN_COLS; c++) begin
            send_put(8'h30 + c, c);
        end
        send_read(0, SCREEN_COLS - 1);
        send_read(0, 0);
        send_read(1, 0);
    endtask

    // Walk down to the last row, then scroll by wrap and by newline.
    task automatic test_bottom_scroll();
        send_word(random_word(tcw_pkg::REQ_CLEAR));
        send_put(8'h54, 8'h70);                           // lands in row 0
        repeat (SCREEN_ROWS - 1) send_put(tcw_pkg::NEWLINE_CHAR, 0);
        for (int c = 0; c < SCREEN_COLS; c++) begin
            send_put(8'h61 + (c % 26), 8'h80 + c);        // last one wraps and scrolls
        end
        send_read(SCREEN_ROWS - 2, 0);
        send_read(SCREEN_ROWS - 2, SCREEN_COLS - 1);
        send_read(SCREEN_ROWS - 1, 0);
        send_put(8'h5A, 8'h4F);
        send_put(tcw_pkg::NEWLINE_CHAR, 8'hFF);           // newline at the bottom
        send_read(SCREEN_ROWS - 2, 0);
        send_read(SCREEN_ROWS - 3, 5);
        send_read(0, 0);                                  // original row 0 is gone
    endtask

    // Mostly lines of text and display reads, with clears and noise.
    task automatic test_random_text(input int item_goal);
        int stop_at;
        int pick;
        int len;
        stop_at = sent_count + item_goal;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // Mostly short lines, now and then one past a full row.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100)
                                                   : $urandom_range(0, 30);
                repeat (len) send_put(text_char(), $urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) begin
                    send_put(tcw_pkg::NEWLINE_CHAR, $urandom_range(0, 255));
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_read($urandom_range(0, 31), $urandom_range(0, 127));
                    end else begin
                        send_read($urandom_range(0, SCREEN_ROWS - 1),
                                  $urandom_range(0, SCREEN_COLS - 1));
                    end
                end
            end else if (pick < 79) begin
                send_word(random_word(tcw_pkg::REQ_CLEAR));
            end else if (pick < 84) begin
                send_word(random_word(tcw_pkg::REQ_NONE));
            end else begin
                // Noise: any code, any content.
                send_word(random_word(tcw_pkg::t_req'($urandom_range(0, 3))));
            end
        end
    endtask

    // Back-to-back words with no gaps to close the run.
    task automatic test_steady_tail();
        idle_on = 1'b0;
        repeat (30) send_put(text_char(), $urandom_range(0, 255));
        send_put(tcw_pkg::NEWLINE_CHAR, 0);
        repeat (10) send_read($urandom_range(0, SCREEN_ROWS - 1),
                              $urandom_range(0, SCREEN_COLS - 1));
        send_word(random_word(tcw_pkg::REQ_NONE));
        send_put(text_char(), $urandom_range(0, 255));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_word         = '0;
        sent_count     = 0;
        checked_count  = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        blank_console();

        // Hold reset low, then release it at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block blanks its store after reset; the handshake waits it out.
        test_basic_requests();
        test_line_wrap();
        test_bottom_scroll();
        test_random_text(RANDOM_ITEMS);
        test_steady_tail();

        @(negedge i_clk);
        start <= 1'b0;

        // Drain outstanding results, then idle before finishing.
        while (pending_console_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("text_console_writer_unit_tb: PASS");
        end else begin
            $display("text_console_writer_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond a run where every word scrolls the screen.
    initial begin
        #100_000_000;
        $display("[%0t] timeout with %0d words outstanding", $realtime,
                 pending_console_words.size());
        $display("text_console_writer_unit_tb: FAIL");
        $finish;
    end

endmodule
